### rtl/core/ucdw_pkg.sv
// Shared types and constants of the USB configuration descriptor walker.
`timescale 1ns / 1ps

package ucdw_pkg;

  typedef enum logic [3:0] {
    KIND_INTF_OK     = 4'd0,
    KIND_ENDP_OK     = 4'd1,
    KIND_ALT_IGNORED = 4'd2,
    KIND_EXCESS_INTF = 4'd3,
    KIND_ORPHAN_ENDP = 4'd4,
    KIND_EXCESS_ENDP = 4'd5,
    KIND_OTHER       = 4'd6,
    KIND_MALFORMED   = 4'd7,
    KIND_EMPTY       = 4'd8
  } record_kind_e;

  localparam logic [7:0]  TYPE_INTERFACE     = 8'd4;
  localparam logic [7:0]  TYPE_ENDPOINT      = 8'd5;
  localparam logic [15:0] CONFIG_HEADER_SIZE = 16'd9;
  localparam logic [7:0]  MIN_HEADER_LENGTH  = 8'd5;

  typedef struct packed {
    record_kind_e kind;
    logic         last_record;
    logic [7:0]   interface_index;
    logic [7:0]   endpoint_index;
    logic [7:0]   descriptor_type;
    logic [7:0]   interface_class;
    logic [7:0]   interface_subclass;
    logic [7:0]   interface_protocol;
    logic [7:0]   declared_endpoints;
    logic [7:0]   endpoint_address;
    logic [7:0]   endpoint_attributes;
    logic [15:0]  max_packet_size;
  } record_t;

endpackage

### rtl/core/usb_config_descriptor_walker.sv
// Top level of the USB configuration descriptor walker.
// The input channel carries one byte of a configuration descriptor set per
// request, with first_byte_i marking byte zero of a new set at any time.
// The walker reads the header length, the total length and the interface
// count, then frames each following descriptor by its length byte.
// When a descriptor ends, one record is sent on the output channel that
// classes it and carries its indices and captured fields.
// A record is registered into the output buffer when the byte that ends it is
// accepted, and one byte can be accepted in every cycle while in_stall_o is low.
// The per-byte work is a single pass of compare and count logic from the
// walker registers to a two-entry output buffer.
// Reset clears the walker to idle, and bytes are dropped until a first byte.
// When the receiver stalls, records collect in the output buffer and the
// input stall rises only once both of its entries are full.

`timescale 1ns / 1ps

module usb_config_descriptor_walker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  record_kind_o,
  output logic        last_record_o,
  output logic [7:0]  interface_index_o,
  output logic [7:0]  endpoint_index_o,
  output logic [7:0]  descriptor_type_o,
  output logic [7:0]  interface_class_o,
  output logic [7:0]  interface_subclass_o,
  output logic [7:0]  interface_protocol_o,
  output logic [7:0]  declared_endpoints_o,
  output logic [7:0]  endpoint_address_o,
  output logic [7:0]  endpoint_attributes_o,
  output logic [15:0] max_packet_size_o
);

  logic [15:0]     pos_q, pos_d;
  logic [15:0]     total_q, total_d;
  logic [7:0]      hdr_len_q, hdr_len_d;
  logic [7:0]      intf_limit_q, intf_limit_d;
  logic [7:0]      accepted_q, accepted_d;
  logic            cur_valid_q, cur_valid_d;
  logic [7:0]      ep_limit_q, ep_limit_d;
  logic [7:0]      ep_count_q, ep_count_d;
  logic [7:0]      offset_q, offset_d;
  logic [7:0]      desc_len_q, desc_len_d;
  logic [7:0][7:0] cap_q, cap_d;
  logic            active_q, active_d;

  logic [15:0]       p;
  logic              last;
  logic              ends;
  logic              emit;
  ucdw_pkg::record_t rec;
  ucdw_pkg::record_t out_rec;
  logic              in_accept;
  logic              buf_full;

  assign in_stall_o = buf_full;
  assign in_accept  = in_valid_i && !buf_full;

  always_comb begin
    pos_d        = pos_q;
    total_d      = total_q;
    hdr_len_d    = hdr_len_q;
    intf_limit_d = intf_limit_q;
    accepted_d   = accepted_q;
    cur_valid_d  = cur_valid_q;
    ep_limit_d   = ep_limit_q;
    ep_count_d   = ep_count_q;
    offset_d     = offset_q;
    desc_len_d   = desc_len_q;
    cap_d        = cap_q;
    active_d     = active_q;
    p            = '0;
    last         = 1'b0;
    ends         = 1'b0;
    emit         = 1'b0;
    rec          = '0;

    if (first_byte_i) begin
      pos_d        = '0;
      total_d      = '0;
      hdr_len_d    = '0;
      intf_limit_d = '0;
      accepted_d   = '0;
      cur_valid_d  = 1'b0;
      ep_limit_d   = '0;
      ep_count_d   = '0;
      offset_d     = '0;
      desc_len_d   = '0;
      cap_d        = '0;
      active_d     = 1'b1;
    end

    if (active_d) begin
      p     = pos_d;
      pos_d = p + 16'd1;
      if (p < 16'd5) begin
        case (p[2:0])
          3'd0: hdr_len_d = data_byte_i;
          3'd2: total_d[7:0] = data_byte_i;
          3'd3: begin
            total_d[15:8] = data_byte_i;
            if (total_d <= ucdw_pkg::CONFIG_HEADER_SIZE) begin
              active_d        = 1'b0;
              emit            = 1'b1;
              rec.kind        = ucdw_pkg::KIND_EMPTY;
              rec.last_record = 1'b1;
            end
          end
          3'd4: begin
            intf_limit_d = data_byte_i;
            if (hdr_len_d < ucdw_pkg::MIN_HEADER_LENGTH) begin
              active_d = 1'b0;
              emit     = 1'b1;
              rec.kind = ucdw_pkg::KIND_MALFORMED;
            end else if ({8'd0, hdr_len_d} >= total_d) begin
              active_d        = 1'b0;
              emit            = 1'b1;
              rec.kind        = ucdw_pkg::KIND_EMPTY;
              rec.last_record = 1'b1;
            end
          end
          default: ;
        endcase
      end else if (p >= {8'd0, hdr_len_d}) begin
        last = ({1'b0, p} + 17'd1) >= {1'b0, total_d};
        if (last) begin
          active_d = 1'b0;
        end
        if (offset_d == 8'd0) begin
          cap_d      = '0;
          desc_len_d = data_byte_i;
        end
        if (offset_d == 8'd0 && data_byte_i == 8'd0) begin
          active_d        = 1'b0;
          emit            = 1'b1;
          rec.kind        = ucdw_pkg::KIND_MALFORMED;
          rec.last_record = last;
        end else begin
          if (offset_d < 8'd8) begin
            cap_d[offset_d[2:0]] = data_byte_i;
          end
          ends = (({1'b0, offset_d} + 9'd1) >= {1'b0, desc_len_d}) || last;
          if (ends) begin
            offset_d            = '0;
            emit                = 1'b1;
            rec.last_record     = last;
            rec.descriptor_type = cap_d[1];
            if (cap_d[1] == ucdw_pkg::TYPE_INTERFACE) begin
              rec.interface_class    = cap_d[5];
              rec.interface_subclass = cap_d[6];
              rec.interface_protocol = cap_d[7];
              rec.declared_endpoints = cap_d[4];
              if (cap_d[3] != 8'd0) begin
                rec.kind    = ucdw_pkg::KIND_ALT_IGNORED;
                cur_valid_d = 1'b0;
              end else if (accepted_d >= intf_limit_d) begin
                rec.kind    = ucdw_pkg::KIND_EXCESS_INTF;
                cur_valid_d = 1'b0;
              end else begin
                rec.kind            = ucdw_pkg::KIND_INTF_OK;
                rec.interface_index = accepted_d;
                accepted_d          = accepted_d + 8'd1;
                cur_valid_d         = 1'b1;
                ep_limit_d          = cap_d[4];
                ep_count_d          = '0;
              end
            end else if (cap_d[1] == ucdw_pkg::TYPE_ENDPOINT) begin
              rec.endpoint_address    = cap_d[2];
              rec.endpoint_attributes = cap_d[3];
              rec.max_packet_size     = {cap_d[5], cap_d[4]};
              if (!cur_valid_d) begin
                rec.kind = ucdw_pkg::KIND_ORPHAN_ENDP;
              end else if (ep_count_d >= ep_limit_d) begin
                rec.kind            = ucdw_pkg::KIND_EXCESS_ENDP;
                rec.interface_index = accepted_d - 8'd1;
              end else begin
                rec.kind            = ucdw_pkg::KIND_ENDP_OK;
                rec.interface_index = accepted_d - 8'd1;
                rec.endpoint_index  = ep_count_d;
                ep_count_d          = ep_count_d + 8'd1;
              end
            end else begin
              rec.kind = ucdw_pkg::KIND_OTHER;
            end
          end else begin
            offset_d = offset_d + 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      total_q      <= '0;
      hdr_len_q    <= '0;
      intf_limit_q <= '0;
      accepted_q   <= '0;
      cur_valid_q  <= 1'b0;
      ep_limit_q   <= '0;
      ep_count_q   <= '0;
      offset_q     <= '0;
      desc_len_q   <= '0;
      cap_q        <= '0;
      active_q     <= 1'b0;
    end else if (in_accept) begin
      pos_q        <= pos_d;
      total_q      <= total_d;
      hdr_len_q    <= hdr_len_d;
      intf_limit_q <= intf_limit_d;
      accepted_q   <= accepted_d;
      cur_valid_q  <= cur_valid_d;
      ep_limit_q   <= ep_limit_d;
      ep_count_q   <= ep_count_d;
      offset_q     <= offset_d;
      desc_len_q   <= desc_len_d;
      cap_q        <= cap_d;
      active_q     <= active_d;
    end
  end

  ucdw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept && emit),
    .push_data_i (rec),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_rec)
  );

  assign record_kind_o         = out_rec.kind;
  assign last_record_o         = out_rec.last_record;
  assign interface_index_o     = out_rec.interface_index;
  assign endpoint_index_o      = out_rec.endpoint_index;
  assign descriptor_type_o     = out_rec.descriptor_type;
  assign interface_class_o     = out_rec.interface_class;
  assign interface_subclass_o  = out_rec.interface_subclass;
  assign interface_protocol_o  = out_rec.interface_protocol;
  assign declared_endpoints_o  = out_rec.declared_endpoints;
  assign endpoint_address_o    = out_rec.endpoint_address;
  assign endpoint_attributes_o = out_rec.endpoint_attributes;
  assign max_packet_size_o     = out_rec.max_packet_size;

endmodule

### rtl/core/ucdw_out_buf.sv
// Two-entry output buffer that holds records while the receiver stalls.
`timescale 1ns / 1ps

module ucdw_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ucdw_pkg::record_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ucdw_pkg::record_t out_data_o
);

  logic              out_valid_q;
  logic              skid_valid_q;
  ucdw_pkg::record_t out_data_q;
  ucdw_pkg::record_t skid_data_q;
  logic              out_ready;

  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_data_q <= skid_valid_q ? skid_data_q : push_data_i;
    end else if (push_i) begin
      skid_data_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
